// ===== rtl/core/ccd_pkg.sv =====
// Shared types and constants of the character cell dedup core.
// Used by character_cell_dedup_core; no dependencies of its own.
`default_nettype none

package ccd_pkg;

  localparam int COL_W        = 6;   // bits of one sixel column
  localparam int GROUP_W      = 48;  // bits of one column group on the port
  localparam int CODE_W       = 7;   // soft character code
  localparam int X_W          = 7;
  localparam int Y_W          = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  localparam int CHAR_SLOTS_DEF = 96;
  localparam int COLUMNS_DEF    = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH      = 2'd2;

  typedef struct packed {
    logic               first_cell;
    logic [X_W-1:0]     cell_x;
    logic [Y_W-1:0]     cell_y;
    logic [GROUP_W-1:0] upper_group;
    logic [GROUP_W-1:0] lower_group;
  } ccd_cell_t;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              new_char;
    logic              exhausted;
    logic [X_W-1:0]    out_x;
    logic [Y_W-1:0]    out_y;
  } ccd_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ccd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ccd_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 96,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/character_cell_dedup_core.sv =====
// Character cell dedup core: assigns soft character codes to sixel cells.
// Depends on ccd_pkg and ccd_ram.
//
// A cell is taken when start is high and busy is low; its result appears on
// result_o for one cycle, marked by done_o, and cannot be held off. An
// all-blank or all-full cell, or any cell while identical matching is off,
// goes from idle straight to the finish state, which registers the result.
// Any other cell is first compared against every stored pattern through the
// single read port of the pattern RAM, one entry a cycle, and then finishes.
// busy stays high until the result is out of the core logic, so a new cell
// may be started in the cycle done_o is high. Configuration writes are
// always ready.
`default_nettype none

module character_cell_dedup_core
  import ccd_pkg::*;
#(
  parameter int CHAR_SLOTS = CHAR_SLOTS_DEF,
  parameter int COLUMNS    = COLUMNS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire ccd_cell_t             cell_i,
  output logic                       done_o,
  output ccd_result_t                result_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W  = (CHAR_SLOTS > 1) ? $clog2(CHAR_SLOTS) : 1;
  localparam int CNT_W  = $clog2(CHAR_SLOTS + 1);
  localparam int HALF_W = COL_W * COLUMNS;
  localparam int PAT_W  = 2 * HALF_W;
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(CHAR_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } ccd_state_e;

  ccd_state_e state_q, state_d;

  // Configuration
  logic [COL_W-1:0] blank_code_q, full_code_q;
  logic             match_q;

  // Record state
  logic [CNT_W-1:0] count_q, count_d;
  logic             blank_seen_q, blank_seen_d;
  logic             full_seen_q, full_seen_d;
  logic [IDX_W-1:0] blank_idx_q, blank_idx_d;
  logic [IDX_W-1:0] full_idx_q, full_idx_d;

  // Per-cell working registers
  logic [PAT_W-1:0] pat_q, pat_d;
  logic             is_blank_q, is_blank_d;
  logic             is_full_q, is_full_d;
  logic [X_W-1:0]   x_q, x_d;
  logic [Y_W-1:0]   y_q, y_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;

  // Result register
  logic        done_q, done_d;
  ccd_result_t res_q, res_d;

  // RAM port
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [PAT_W-1:0] rdata;

  // Uniform cell detection on the incoming cell
  logic in_blank, in_full;
  logic accept;

  // Finish stage decision
  logic             reuse_blank, reuse_full, reused, room, store;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] fin_idx;
  logic             issue;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = res_q;

  always_comb begin
    in_blank = 1'b1;
    in_full  = 1'b1;
    for (int i = 0; i < COLUMNS; i++) begin
      if (cell_i.upper_group[COL_W*i +: COL_W] != blank_code_q) in_blank = 1'b0;
      if (cell_i.lower_group[COL_W*i +: COL_W] != blank_code_q) in_blank = 1'b0;
      if (cell_i.upper_group[COL_W*i +: COL_W] != full_code_q)  in_full  = 1'b0;
      if (cell_i.lower_group[COL_W*i +: COL_W] != full_code_q)  in_full  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_code_q <= '0;
      full_code_q  <= '1;
      match_q      <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BLANK_CODE: blank_code_q <= cfg_data_i;
        CFG_FULL_CODE:  full_code_q  <= cfg_data_i;
        CFG_MATCH:      match_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign reuse_blank = is_blank_q && blank_seen_q;
  assign reuse_full  = is_full_q && full_seen_q;
  assign reused      = reuse_blank || reuse_full || hit_q;
  assign room        = (count_q < SLOTS_CNT);
  assign store       = !reused && room;
  assign count_next  = store ? count_q + 1'b1 : count_q;
  assign issue       = (scan_q < count_q);

  always_comb begin
    if (reuse_blank) begin
      fin_idx = blank_idx_q;
    end else if (reuse_full) begin
      fin_idx = full_idx_q;
    end else if (hit_q) begin
      fin_idx = hit_idx_q;
    end else if (room) begin
      fin_idx = count_q[IDX_W-1:0];
    end else begin
      fin_idx = '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    blank_seen_d = blank_seen_q;
    full_seen_d  = full_seen_q;
    blank_idx_d  = blank_idx_q;
    full_idx_d   = full_idx_q;
    pat_d        = pat_q;
    is_blank_d   = is_blank_q;
    is_full_d    = is_full_q;
    x_d          = x_q;
    y_d          = y_q;
    scan_d       = scan_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    done_d       = 1'b0;
    res_d        = res_q;
    we           = 1'b0;
    waddr        = count_q[IDX_W-1:0];
    raddr        = scan_q[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cell_i.first_cell) begin
            count_d      = '0;
            blank_seen_d = 1'b0;
            full_seen_d  = 1'b0;
          end
          pat_d      = {cell_i.lower_group[HALF_W-1:0], cell_i.upper_group[HALF_W-1:0]};
          is_blank_d = in_blank;
          is_full_d  = in_full && !in_blank;
          x_d        = cell_i.cell_x;
          y_d        = cell_i.cell_y;
          scan_d     = '0;
          hit_d      = 1'b0;
          // Uniform cells never go through the pattern compare
          if (!in_blank && !in_full && match_q) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
          scan_d   = scan_q + 1'b1;
        end
        // Ascending scan: the latest hit is the highest index
        if (rd_vld_q && (rdata == pat_q)) begin
          hit_d     = 1'b1;
          hit_idx_d = rd_idx_q;
        end
        if (!issue && !rd_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (store) begin
          we      = 1'b1;
          count_d = count_next;
          if (is_blank_q) begin
            blank_seen_d = 1'b1;
            blank_idx_d  = count_q[IDX_W-1:0];
          end
          if (is_full_q) begin
            full_seen_d = 1'b1;
            full_idx_d  = count_q[IDX_W-1:0];
          end
        end
        res_d.char_code = CODE_W'(fin_idx);
        res_d.new_char  = store;
        res_d.exhausted = (count_next >= SLOTS_CNT);
        res_d.out_x     = x_q;
        res_d.out_y     = y_q;
        done_d          = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      blank_seen_q <= 1'b0;
      full_seen_q  <= 1'b0;
      rd_vld_q     <= 1'b0;
      hit_q        <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      blank_seen_q <= blank_seen_d;
      full_seen_q  <= full_seen_d;
      rd_vld_q     <= rd_vld_d;
      hit_q        <= hit_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blank_idx_q <= blank_idx_d;
    full_idx_q  <= full_idx_d;
    pat_q       <= pat_d;
    is_blank_q  <= is_blank_d;
    is_full_q   <= is_full_d;
    x_q         <= x_d;
    y_q         <= y_d;
    scan_q      <= scan_d;
    rd_idx_q    <= rd_idx_d;
    hit_idx_q   <= hit_idx_d;
    res_q       <= res_d;
  end

  ccd_ram #(
    .WIDTH (PAT_W),
    .DEPTH (CHAR_SLOTS)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (pat_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // A result strobe follows the finish state and nothing else
  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FINISH))
    else $error("result strobe without a finished cell");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SLOTS_CNT)
    else $error("used count beyond the store depth");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (count_q < SLOTS_CNT) && (state_q == ST_FINISH))
    else $error("pattern write outside the free range");

  a_hit_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_q && (state_q != ST_IDLE)) |-> (CNT_W'(hit_idx_q) < count_q))
    else $error("pattern hit on an unused entry");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for character_cell_dedup_core: sends character cells over start/busy,
// predicts each soft character code and checks every result field by field.
// Depends on ccd_pkg and the core RTL only.

module testbench;
  import ccd_pkg::*;

  localparam int SLOTS     = CHAR_SLOTS_DEF;
  localparam int COLS      = COLUMNS_DEF;
  localparam int ITEM_GOAL = 1350;
  localparam int PAL_SIZE  = 12;
  localparam logic [GROUP_W-1:0] GROUP_MASK = {GROUP_W{1'b1}} >> (GROUP_W - COL_W * COLS);

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  ccd_cell_t             cell_i      = '0;
  logic                  done_o;
  ccd_result_t           result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_BLANK_CODE;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  character_cell_dedup_core #(
    .CHAR_SLOTS(SLOTS),
    .COLUMNS   (COLS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cell_i     (cell_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the core's registers and character store
  logic [COL_W-1:0]     cfg_blank = 6'd0;
  logic [COL_W-1:0]     cfg_full  = 6'd63;
  logic                 cfg_match = 1'b1;
  logic [2*GROUP_W-1:0] slot_pattern [SLOTS];
  int                   slots_used  = 0;
  bit                   blank_known = 1'b0;
  bit                   full_known  = 1'b0;
  logic [CODE_W-1:0]    blank_slot;
  logic [CODE_W-1:0]    full_slot;

  ccd_result_t owed_codes [$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          steady     = 1'b0;

  function automatic bit is_uniform(logic [GROUP_W-1:0] up, logic [GROUP_W-1:0] lo,
                                    logic [COL_W-1:0] v);
    for (int i = 0; i < COLS; i++) begin
      if (up[COL_W*i +: COL_W] != v || lo[COL_W*i +: COL_W] != v) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic ccd_result_t predict_char_code(ccd_cell_t c);
    logic [GROUP_W-1:0] up;
    logic [GROUP_W-1:0] lo;
    logic [CODE_W-1:0]  code;
    bit                 reused;
    bit                 is_new;
    bit                 mark_blank;
    bit                 mark_full;
    ccd_result_t        r;
    up         = c.upper_group & GROUP_MASK;
    lo         = c.lower_group & GROUP_MASK;
    code       = '0;
    reused     = 1'b0;
    is_new     = 1'b0;
    mark_blank = 1'b0;
    mark_full  = 1'b0;
    if (c.first_cell) begin
      slots_used  = 0;
      blank_known = 1'b0;
      full_known  = 1'b0;
    end
    if (is_uniform(up, lo, cfg_blank)) begin
      if (blank_known) begin
        code   = blank_slot;
        reused = 1'b1;
      end else begin
        mark_blank = 1'b1;
      end
    end else if (is_uniform(up, lo, cfg_full)) begin
      if (full_known) begin
        code   = full_slot;
        reused = 1'b1;
      end else begin
        mark_full = 1'b1;
      end
    end else if (cfg_match) begin
      // later entries override earlier ones: highest index wins
      for (int k = 0; k < slots_used; k++) begin
        if (slot_pattern[k] == {up, lo}) begin
          code   = CODE_W'(k);
          reused = 1'b1;
        end
      end
    end
    if (!reused && slots_used < SLOTS) begin
      code                     = CODE_W'(slots_used);
      slot_pattern[slots_used] = {up, lo};
      if (mark_blank) begin
        blank_known = 1'b1;
        blank_slot  = code;
      end
      if (mark_full) begin
        full_known = 1'b1;
        full_slot  = code;
      end
      slots_used++;
      is_new = 1'b1;
    end
    r.char_code = code;
    r.new_char  = is_new;
    r.exhausted = (slots_used >= SLOTS);
    r.out_x     = c.cell_x;
    r.out_y     = c.cell_y;
    return r;
  endfunction

  function automatic logic [GROUP_W-1:0] fill_group(logic [COL_W-1:0] v);
    return {(GROUP_W/COL_W){v}};
  endfunction

  function automatic logic [GROUP_W-1:0] rand_group();
    return GROUP_W'({$urandom(), $urandom()});
  endfunction

  function automatic ccd_cell_t build_cell_at(bit first, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                              logic [GROUP_W-1:0] up, logic [GROUP_W-1:0] lo);
    ccd_cell_t c;
    c.first_cell  = first;
    c.cell_x      = x;
    c.cell_y      = y;
    c.upper_group = up;
    c.lower_group = lo;
    return c;
  endfunction

  function automatic ccd_cell_t build_cell(bit first, logic [GROUP_W-1:0] up,
                                           logic [GROUP_W-1:0] lo);
    return build_cell_at(first, X_W'($urandom), Y_W'($urandom), up, lo);
  endfunction

  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) flag($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
  endtask

  // Results cannot be held off: take one whenever done_o is high
  always @(posedge clk_i) begin
    ccd_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (owed_codes.size() == 0) begin
        flag($sformatf("unexpected result: char_code %0h", result_o.char_code));
      end else begin
        want = owed_codes.pop_front();
        check_field("char_code", 8'(want.char_code), 8'(result_o.char_code));
        check_field("new_char",  8'(want.new_char),  8'(result_o.new_char));
        check_field("exhausted", 8'(want.exhausted), 8'(result_o.exhausted));
        check_field("out_x",     8'(want.out_x),     8'(result_o.out_x));
        check_field("out_y",     8'(want.out_y),     8'(result_o.out_y));
      end
    end
  end

  // Called at a rising edge; returns at the edge of the transfer with start still high
  task automatic send_cell(ccd_cell_t c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    cell_i <= c;
    do @(posedge clk_i); while (busy);
    owed_codes.push_back(predict_char_code(c));
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (owed_codes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BLANK_CODE: cfg_blank = data;
      CFG_FULL_CODE:  cfg_full  = data;
      CFG_MATCH:      cfg_match = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [COL_W-1:0] blank, logic [COL_W-1:0] full, logic match);
    logic [CFG_DATA_W-1:0] match_word;
    match_word    = CFG_DATA_W'($urandom);
    match_word[0] = match;
    drain();
    write_reg(CFG_BLANK_CODE, blank);
    write_reg(CFG_FULL_CODE, full);
    write_reg(CFG_MATCH, match_word);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    logic [GROUP_W-1:0] pu;
    logic [GROUP_W-1:0] pl;
    pu = rand_group();
    pl = rand_group();
    send_cell(build_cell(1'b1, fill_group(6'd0), fill_group(6'd0)));
    send_cell(build_cell(1'b0, fill_group(6'd0), fill_group(6'd0)));
    send_cell(build_cell(1'b0, fill_group(6'd63), fill_group(6'd63)));
    send_cell(build_cell(1'b0, fill_group(6'd63), fill_group(6'd63)));
    send_cell(build_cell_at(1'b0, 7'd127, 6'd63, pu, pl));
    send_cell(build_cell_at(1'b0, 7'd0, 6'd0, pu, pl));
    send_cell(build_cell(1'b0, {GROUP_W{1'b1}}, '0));
    send_cell(build_cell(1'b0, '0, {GROUP_W{1'b1}}));
    // clear the counters with a blank cell
    send_cell(build_cell(1'b1, fill_group(6'd0), fill_group(6'd0)));
  endtask

  task automatic test_match_off();
    logic [GROUP_W-1:0] pu;
    logic [GROUP_W-1:0] pl;
    pu = rand_group();
    pl = rand_group();
    apply_config(6'd0, 6'd63, 1'b0);
    send_cell(build_cell(1'b1, pu, pl));
    send_cell(build_cell(1'b0, pu, pl));
    send_cell(build_cell(1'b0, fill_group(6'd0), fill_group(6'd0)));
    send_cell(build_cell(1'b0, fill_group(6'd0), fill_group(6'd0)));
    // duplicates now stored: the later copy must win
    apply_config(6'd0, 6'd63, 1'b1);
    send_cell(build_cell(1'b0, pu, pl));
  endtask

  task automatic test_equal_codes();
    apply_config(6'd21, 6'd21, 1'b1);
    send_cell(build_cell(1'b1, fill_group(6'd21), fill_group(6'd21)));
    send_cell(build_cell(1'b0, fill_group(6'd21), fill_group(6'd21)));
    send_cell(build_cell(1'b0, fill_group(6'd63), fill_group(6'd63)));
    send_cell(build_cell(1'b0, fill_group(6'd63), fill_group(6'd63)));
  endtask

  task automatic test_code_extremes();
    apply_config(6'd63, 6'd0, 1'b1);
    send_cell(build_cell(1'b1, fill_group(6'd63), fill_group(6'd63)));
    send_cell(build_cell(1'b0, fill_group(6'd0), fill_group(6'd0)));
    send_cell(build_cell(1'b0, fill_group(6'd63), fill_group(6'd63)));
    send_cell(build_cell(1'b0, fill_group(6'd0), fill_group(6'd0)));
  endtask

  task automatic test_store_exhaustion();
    logic [GROUP_W-1:0] ku;
    logic [GROUP_W-1:0] kl;
    logic [GROUP_W-1:0] up;
    logic [GROUP_W-1:0] lo;
    apply_config(6'd0, 6'd63, 1'b1);
    ku = rand_group();
    kl = rand_group();
    send_cell(build_cell(1'b1, ku, kl));
    for (int n = 1; n < SLOTS + 6; n++) begin
      up = rand_group();
      lo = rand_group();
      send_cell(build_cell(1'b0, up, lo));
    end
    // blank and full never seen: nothing left to store them in
    send_cell(build_cell(1'b0, fill_group(6'd0), fill_group(6'd0)));
    send_cell(build_cell(1'b0, ku, kl));
    send_cell(build_cell(1'b0, fill_group(6'd63), fill_group(6'd63)));
    send_cell(build_cell(1'b1, fill_group(6'd0), fill_group(6'd0)));
  endtask

  task automatic test_random_images();
    logic [2*GROUP_W-1:0] palette [PAL_SIZE];
    logic [GROUP_W-1:0]   up;
    logic [GROUP_W-1:0]   lo;
    logic [COL_W-1:0]     v;
    bit                   first;
    int                   len;
    int                   pal_n;
    int                   rand_pct;
    int                   roll;
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0: apply_config(6'd0, 6'd63, 1'b1);
          1: apply_config(6'd63, 6'd0, 1'b1);
          2: begin
            v = COL_W'($urandom);
            apply_config(v, v, $urandom_range(0, 3) != 0);
          end
          3: apply_config(COL_W'($urandom), COL_W'($urandom), 1'b0);
          default: apply_config(COL_W'($urandom), COL_W'($urandom), $urandom_range(0, 3) != 0);
        endcase
      end
      steady = ($urandom_range(0, 3) == 0);
      // now and then a long image of mostly unique cells to fill the store
      if ($urandom_range(0, 9) == 0) begin
        len      = $urandom_range(110, 130);
        rand_pct = 80;
      end else begin
        len      = $urandom_range(4, 40);
        rand_pct = 20;
      end
      pal_n = $urandom_range(1, PAL_SIZE);
      for (int i = 0; i < pal_n; i++) palette[i] = {rand_group(), rand_group()};
      for (int n = 0; n < len; n++) begin
        up = rand_group();
        lo = rand_group();
        if ($urandom_range(0, 99) >= rand_pct) begin
          roll = $urandom_range(0, 99);
          if (roll < 50) begin
            {up, lo} = palette[$urandom_range(0, pal_n - 1)];
          end else if (roll < 65) begin
            up = fill_group(cfg_blank);
            lo = up;
          end else if (roll < 77) begin
            up = fill_group(cfg_full);
            lo = up;
          end else if (roll < 85) begin
            v  = COL_W'($urandom);
            up = fill_group(v);
            lo = up;
          end else if (roll < 90) begin
            up = fill_group(cfg_blank);
            lo = fill_group(cfg_full);
          end else begin
            // one bit away from a blank cell
            up = fill_group(cfg_blank);
            lo = up;
            lo[$urandom_range(0, GROUP_W - 1)] ^= 1'b1;
          end
        end
        first = (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
        send_cell(build_cell(first, up, lo));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_match_off();
    test_equal_codes();
    test_code_extremes();
    test_store_exhaustion();
    test_random_images();
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && owed_codes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
